// File: rtl/core/tct_pkg.sv
// shared types and constants for the tcp connection tracker
`default_nettype none
package tct_pkg;

  localparam int TABLE_ENTRIES   = 1024;
  localparam int BYTE_COUNT_BITS = 48;
  localparam int IDX_W           = $clog2(TABLE_ENTRIES);
  localparam int PTR_W           = IDX_W + 1;
  localparam int KEY_W           = 96;
  localparam int EXP_W           = 11;
  localparam int QUEUE_DEPTH     = 2;
  localparam logic [PTR_W-1:0] NONE_PTR = PTR_W'(TABLE_ENTRIES);
  localparam logic [31:0]      TIMEOUT_RESET = 32'd7200;

  // result status codes
  typedef enum logic [2:0] {
    ST_IGNORED = 3'd0,
    ST_CREATED = 3'd1,
    ST_UPDATED = 3'd2,
    ST_CLOSED  = 3'd3,
    ST_FULL    = 3'd4,
    ST_SWEEP   = 3'd5
  } status_t;

  // classified command handed from front to back
  typedef struct packed {
    logic             sweep;
    logic [KEY_W-1:0] key;
    logic [15:0]      up_len;
    logic [15:0]      dn_len;
    logic             syn_ack;
    logic             close;
    logic             pay_nz;
    logic [31:0]      now;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPD_WR,
    S_CREATE1,
    S_CREATE2,
    S_UNL_WR,
    S_SW_CHK,
    S_SW_CMP,
    S_OUT
  } eng_state_t;

endpackage
`default_nettype wire

// File: rtl/core/tct_front.sv
// front end: normalizes the connection key and classifies the item
`default_nettype none
module tct_front import tct_pkg::*; (
  input  wire logic        action,
  input  wire logic [31:0] src_addr,
  input  wire logic [31:0] dst_addr,
  input  wire logic [15:0] src_port,
  input  wire logic [15:0] dst_port,
  input  wire logic        flag_syn,
  input  wire logic        flag_ack,
  input  wire logic        flag_rst,
  input  wire logic        flag_fin,
  input  wire logic [15:0] payload_len,
  input  wire logic [31:0] now_time,
  output cmd_t             cmd
);

  logic hi_first;

  // higher or equal port leads the key
  assign hi_first = (src_port >= dst_port);

  always_comb begin
    cmd.sweep   = action;
    cmd.key     = hi_first ? {src_addr, dst_addr, src_port, dst_port}
                           : {dst_addr, src_addr, dst_port, src_port};
    cmd.up_len  = hi_first ? payload_len : 16'd0;
    cmd.dn_len  = hi_first ? 16'd0 : payload_len;
    cmd.syn_ack = flag_syn & flag_ack;
    cmd.close   = flag_rst | flag_fin;
    cmd.pay_nz  = (payload_len != 16'd0);
    cmd.now     = now_time;
  end

endmodule
`default_nettype wire

// File: rtl/core/tct_queue.sv
// short command queue between front and back
`default_nettype none
module tct_queue import tct_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  cmd_t      push_cmd,
  output logic      pop_valid,
  input  wire logic pop,
  output cmd_t      pop_cmd
);

  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr_r;
  logic [QP_W-1:0]  rd_ptr_r;
  logic [QC_W-1:0]  count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != QC_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/tct_engine.sv
// back end: table search, entry update, sweep and creation-order list upkeep
`default_nettype none
module tct_engine import tct_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  cmd_t             q_cmd,
  input  wire logic [31:0] idle_timeout,
  output logic             res_valid,
  input  wire logic        res_ready,
  output status_t          res_status,
  output logic             res_first,
  output logic [EXP_W-1:0] res_expired
);

  localparam logic [BYTE_COUNT_BITS-1:0] BYTE_MAX = '1;

  // table memories
  logic [KEY_W:0]                key_mem [TABLE_ENTRIES];
  logic [31:0]                   ls_mem  [TABLE_ENTRIES];
  logic [BYTE_COUNT_BITS-1:0]    up_mem  [TABLE_ENTRIES];
  logic [BYTE_COUNT_BITS-1:0]    dn_mem  [TABLE_ENTRIES];
  logic [PTR_W-1:0]              nw_mem  [TABLE_ENTRIES];
  logic [PTR_W-1:0]              od_mem  [TABLE_ENTRIES];

  logic [KEY_W:0]             key_q;
  logic [31:0]                ls_q;
  logic [BYTE_COUNT_BITS-1:0] up_q;
  logic [BYTE_COUNT_BITS-1:0] dn_q;
  logic [PTR_W-1:0]           nw_q;
  logic [PTR_W-1:0]           od_q;

  eng_state_t        state_r;
  eng_state_t        state_nxt;
  cmd_t              cmd_r;
  logic [PTR_W-1:0]  cnt_r;
  logic              chk_vld_r;
  logic [IDX_W-1:0]  chk_idx_r;
  logic              hit_r;
  logic [IDX_W-1:0]  idx_r;
  logic              free_vld_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic [PTR_W-1:0]  prev_newest_r;
  logic [PTR_W-1:0]  newest_r;
  logic [PTR_W-1:0]  oldest_r;
  logic [PTR_W-1:0]  live_r;
  logic [PTR_W-1:0]  guard_r;
  status_t           status_r;
  logic              first_r;
  logic [EXP_W-1:0]  expired_r;

  logic [IDX_W-1:0]           rd_addr;
  logic                       key_we;
  logic [IDX_W-1:0]           key_wa;
  logic [KEY_W:0]             key_wd;
  logic                       dat_we;
  logic [BYTE_COUNT_BITS-1:0] up_wd;
  logic [BYTE_COUNT_BITS-1:0] dn_wd;
  logic                       nw_we;
  logic [IDX_W-1:0]           nw_wa;
  logic [PTR_W-1:0]           nw_wd;
  logic                       od_we;
  logic [IDX_W-1:0]           od_wa;
  logic [PTR_W-1:0]           od_wd;

  logic match;
  logic scan_last;
  logic fresh;
  logic sweep_end;
  logic table_full;

  function automatic logic [BYTE_COUNT_BITS-1:0] sat_add(
    input logic [BYTE_COUNT_BITS-1:0] a,
    input logic [15:0]                b
  );
    logic [BYTE_COUNT_BITS:0] sum;
    sum = {1'b0, a} + (BYTE_COUNT_BITS + 1)'(b);
    return sum[BYTE_COUNT_BITS] ? BYTE_MAX : sum[BYTE_COUNT_BITS-1:0];
  endfunction

  // search compare on registered key data
  assign match     = chk_vld_r & key_q[KEY_W] & (key_q[KEY_W-1:0] == cmd_r.key);
  assign scan_last = chk_vld_r & (chk_idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign fresh     = ({1'b0, ls_q} + {1'b0, idle_timeout}) > {1'b0, cmd_r.now};
  assign sweep_end = (oldest_r == NONE_PTR) | (guard_r == PTR_W'(TABLE_ENTRIES));
  assign table_full = (live_r == PTR_W'(TABLE_ENTRIES));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:   if (cnt_r == PTR_W'(TABLE_ENTRIES - 1)) state_nxt = S_IDLE;
      S_IDLE:    if (q_valid) state_nxt = q_cmd.sweep ? S_SW_CHK : S_SCAN;
      S_SCAN:    if (match || scan_last) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (hit_r) begin
          state_nxt = cmd_r.close ? S_UNL_WR : S_UPD_WR;
        end else if (cmd_r.syn_ack && !table_full) begin
          state_nxt = S_CREATE1;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_UPD_WR:  state_nxt = S_OUT;
      S_CREATE1: state_nxt = (newest_r != NONE_PTR) ? S_CREATE2 : S_OUT;
      S_CREATE2: state_nxt = S_OUT;
      S_UNL_WR:  state_nxt = cmd_r.sweep ? S_SW_CHK : S_OUT;
      S_SW_CHK:  state_nxt = sweep_end ? S_OUT : S_SW_CMP;
      S_SW_CMP:  state_nxt = fresh ? S_OUT : S_UNL_WR;
      S_OUT:     if (res_ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // memory controls and handshake outputs
  always_comb begin
    q_pop   = 1'b0;
    rd_addr = idx_r;
    key_we  = 1'b0;
    key_wa  = idx_r;
    key_wd  = '0;
    dat_we  = 1'b0;
    up_wd   = BYTE_COUNT_BITS'(cmd_r.up_len);
    dn_wd   = BYTE_COUNT_BITS'(cmd_r.dn_len);
    nw_we   = 1'b0;
    nw_wa   = idx_r;
    nw_wd   = NONE_PTR;
    od_we   = 1'b0;
    od_wa   = idx_r;
    od_wd   = newest_r;
    unique case (state_r)
      S_CLEAR: begin
        key_we = 1'b1;
        key_wa = cnt_r[IDX_W-1:0];
      end
      S_IDLE:   q_pop = q_valid;
      S_SCAN:   rd_addr = cnt_r[IDX_W-1:0];
      S_UPD_WR: begin
        dat_we = 1'b1;
        up_wd  = sat_add(up_q, cmd_r.up_len);
        dn_wd  = sat_add(dn_q, cmd_r.dn_len);
      end
      S_CREATE1: begin
        key_we = 1'b1;
        key_wd = {1'b1, cmd_r.key};
        dat_we = 1'b1;
        nw_we  = 1'b1;
        od_we  = 1'b1;
      end
      S_CREATE2: begin
        nw_we = 1'b1;
        nw_wa = prev_newest_r[IDX_W-1:0];
        nw_wd = {1'b0, idx_r};
      end
      S_UNL_WR: begin
        key_we = 1'b1;
        nw_we  = (od_q != NONE_PTR);
        nw_wa  = od_q[IDX_W-1:0];
        nw_wd  = nw_q;
        od_we  = (nw_q != NONE_PTR);
        od_wa  = nw_q[IDX_W-1:0];
        od_wd  = od_q;
      end
      S_SW_CHK: rd_addr = oldest_r[IDX_W-1:0];
      default: begin
      end
    endcase
  end

  assign res_valid   = (state_r == S_OUT);
  assign res_status  = status_r;
  assign res_first   = first_r;
  assign res_expired = expired_r;

  // table memories with registered reads
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    if (dat_we) begin
      ls_mem[idx_r] <= cmd_r.now;
      up_mem[idx_r] <= up_wd;
      dn_mem[idx_r] <= dn_wd;
    end
    if (nw_we) nw_mem[nw_wa] <= nw_wd;
    if (od_we) od_mem[od_wa] <= od_wd;
    key_q <= key_mem[rd_addr];
    ls_q  <= ls_mem[rd_addr];
    up_q  <= up_mem[rd_addr];
    dn_q  <= dn_mem[rd_addr];
    nw_q  <= nw_mem[rd_addr];
    od_q  <= od_mem[rd_addr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // list pointers, occupancy and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      chk_vld_r <= 1'b0;
      newest_r  <= NONE_PTR;
      oldest_r  <= NONE_PTR;
      live_r    <= '0;
    end else begin
      case (state_r)
        S_CLEAR: cnt_r <= cnt_r + 1'b1;
        S_IDLE: begin
          cnt_r     <= '0;
          chk_vld_r <= 1'b0;
        end
        S_SCAN: begin
          chk_vld_r <= (cnt_r != PTR_W'(TABLE_ENTRIES));
          if (cnt_r != PTR_W'(TABLE_ENTRIES)) cnt_r <= cnt_r + 1'b1;
        end
        S_CREATE1: begin
          newest_r <= {1'b0, idx_r};
          if (newest_r == NONE_PTR) oldest_r <= {1'b0, idx_r};
          live_r <= live_r + 1'b1;
        end
        S_UNL_WR: begin
          if (nw_q == NONE_PTR) newest_r <= od_q;
          if (od_q == NONE_PTR) oldest_r <= nw_q;
          if (live_r != '0) live_r <= live_r - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // per-item working registers and result fields
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cmd_r      <= q_cmd;
          free_vld_r <= 1'b0;
          hit_r      <= 1'b0;
          guard_r    <= '0;
          expired_r  <= '0;
          first_r    <= 1'b0;
          status_r   <= ST_IGNORED;
        end
      end
      S_SCAN: begin
        chk_idx_r <= cnt_r[IDX_W-1:0];
        hit_r     <= match;
        if (match) idx_r <= chk_idx_r;
        if (chk_vld_r && !key_q[KEY_W] && !free_vld_r) begin
          free_vld_r <= 1'b1;
          free_idx_r <= chk_idx_r;
        end
      end
      S_DECIDE: begin
        if (hit_r && cmd_r.close) begin
          status_r <= ST_CLOSED;
        end else if (!hit_r && cmd_r.syn_ack) begin
          if (table_full) begin
            status_r <= ST_FULL;
          end else begin
            idx_r <= free_idx_r;
          end
        end
      end
      S_UPD_WR: begin
        status_r <= ST_UPDATED;
        first_r  <= cmd_r.pay_nz & (up_q == '0) & (dn_q == '0);
      end
      S_CREATE1: begin
        status_r      <= ST_CREATED;
        first_r       <= cmd_r.pay_nz;
        prev_newest_r <= newest_r;
      end
      S_UNL_WR: begin
        if (cmd_r.sweep) begin
          guard_r <= guard_r + 1'b1;
          if (expired_r != '1) expired_r <= expired_r + 1'b1;
        end
      end
      S_SW_CHK: begin
        if (sweep_end) begin
          status_r <= ST_SWEEP;
        end else begin
          idx_r <= oldest_r[IDX_W-1:0];
        end
      end
      S_SW_CMP: if (fresh) status_r <= ST_SWEEP;
      default: begin
      end
    endcase
  end

  // occupancy never exceeds the table
  assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= PTR_W'(TABLE_ENTRIES))
    else $error("live count beyond table size");

  // both list ends are empty together
  assert property (@(posedge clk) disable iff (!rst_n)
    (newest_r == NONE_PTR) == (oldest_r == NONE_PTR))
    else $error("list ends disagree");

  // empty list means no live entries
  assert property (@(posedge clk) disable iff (!rst_n)
    (live_r == '0) == (newest_r == NONE_PTR))
    else $error("live count and list disagree");

  // only sweeps report removed entries
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_status != ST_SWEEP) |-> (res_expired == '0))
    else $error("expired count on a packet result");

endmodule
`default_nettype wire

// File: rtl/core/tcp_connection_tracker.sv
// top level of the tcp connection tracker
//
//   channel | signals                               | transfer when
//   in      | in_valid/in_ready, in_* fields        | in_valid & in_ready
//   out     | out_valid/out_ready, out_* fields     | out_valid & out_ready
//   cfg     | cfg_we, cfg_wdata (idle timeout)      | cfg_we
//
// after reset a clearing pass marks every table entry empty;
// input transfers are queued meanwhile, the back end starts once it ends.
// for a packet the key search reads one table entry per cycle from the key
// memory, stopping at a match or the last entry, then the back end decides,
// writes and presents the result.
// a sweep unlinks the oldest entries in turn while they have outlived the idle timeout.
// a two-entry queue lets the front keep accepting, until it fills, while the
// back end works or while a result waits on out_ready.
`default_nettype none
module tcp_connection_tracker import tct_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [31:0] in_src_addr,
  input  wire logic [31:0] in_dst_addr,
  input  wire logic [15:0] in_src_port,
  input  wire logic [15:0] in_dst_port,
  input  wire logic        in_flag_syn,
  input  wire logic        in_flag_ack,
  input  wire logic        in_flag_rst,
  input  wire logic        in_flag_fin,
  input  wire logic [15:0] in_payload_len,
  input  wire logic [31:0] in_now_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic             out_first_data,
  output logic [10:0]      out_expired_count,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  logic [31:0] idle_timeout_r;
  cmd_t        front_cmd;
  cmd_t        q_cmd;
  logic        q_valid;
  logic        q_pop;
  status_t     res_status;

  // timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      idle_timeout_r <= cfg_wdata;
    end
  end

  // front end classification
  tct_front u_front (
    .action      (in_action),
    .src_addr    (in_src_addr),
    .dst_addr    (in_dst_addr),
    .src_port    (in_src_port),
    .dst_port    (in_dst_port),
    .flag_syn    (in_flag_syn),
    .flag_ack    (in_flag_ack),
    .flag_rst    (in_flag_rst),
    .flag_fin    (in_flag_fin),
    .payload_len (in_payload_len),
    .now_time    (in_now_time),
    .cmd         (front_cmd)
  );

  // command queue
  tct_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  // back end
  tct_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_cmd        (q_cmd),
    .idle_timeout (idle_timeout_r),
    .res_valid    (out_valid),
    .res_ready    (out_ready),
    .res_status   (res_status),
    .res_first    (out_first_data),
    .res_expired  (out_expired_count)
  );

  assign out_status = res_status;

endmodule
`default_nettype wire
